FILE: src/bb3_pkg.sv
package bb3_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;

  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned IMG_WIDTH_W  = 11;
  localparam int unsigned IMG_HEIGHT_W = 12;

  localparam logic [IMG_WIDTH_W-1:0]  DEF_IMAGE_WIDTH  = 11'd1024;
  localparam logic [IMG_HEIGHT_W-1:0] DEF_IMAGE_HEIGHT = 12'd768;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned PIX_W       = 24;
  localparam int unsigned SUM_W       = 12;   // up to nine 8-bit values
  localparam int unsigned T_W         = 13;   // 2*sum + n
  localparam int unsigned CNT_W       = 4;    // pixel count 1..9
  localparam int unsigned DIV_SHIFT   = 20;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned PROD_W      = T_W + RECIP_W;
  localparam int unsigned QUEUE_DEPTH = 4;

  // ceil(2^DIV_SHIFT / (2n)); exact floor division for any t below 2^T_W
  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(((1 << DIV_SHIFT) + 1) / 2);
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(((1 << DIV_SHIFT) + 3) / 4);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(((1 << DIV_SHIFT) + 5) / 6);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(((1 << DIV_SHIFT) + 7) / 8);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(((1 << DIV_SHIFT) + 11) / 12);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(((1 << DIV_SHIFT) + 17) / 18);

  typedef logic [PIX_W-1:0] pixel_t;             // red in the low byte
  typedef logic [2:0][PIX_W-1:0] column_t;       // 0 top, 1 middle, 2 bottom

  typedef enum logic [1:0] {
    OP_PIXEL       = 2'd0,
    OP_FLUSH_WIN   = 2'd1,
    OP_FLUSH_STORE = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     emit;
    logic     last;
    logic     top_ok;
    logic     bot_ok;
    logic     left_ok;
    logic     right_ok;
    logic     wr_bank;    // bank holding the upper row; pixels write here
    pixel_t   px;
  } op_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      4'd1:    r = RECIP_1;
      4'd2:    r = RECIP_2;
      4'd3:    r = RECIP_3;
      4'd4:    r = RECIP_4;
      4'd6:    r = RECIP_6;
      4'd9:    r = RECIP_9;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/bb3_queue.sv
module bb3_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = bb3_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: src/bb3_front.sv
module bb3_front #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  bb3_pkg::pixel_t                 in_px,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            push,
  output bb3_pkg::op_t                    push_op,
  output logic [CW-1:0]                   push_addr,
  input  logic                            q_full
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = bb3_pkg::IMG_HEIGHT_W;

  logic [bb3_pkg::IMG_WIDTH_W-1:0] image_width;
  logic [HW-1:0]                   image_height;
  logic [CW-1:0]                   in_col;
  logic [HW-1:0]                   in_row;
  logic [CW-1:0]                   out_col;
  logic [HW-1:0]                   out_row;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          accept;
  logic          is_flush;
  logic          all_in;
  logic          in_col_end;
  logic          out_col_end;
  logic          out_row_end;
  logic          pix_emit;
  logic          out_adv;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign is_flush  = (in_cmd == bb3_pkg::CMD_FLUSH);

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(image_width) > int'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
  end

  assign eff_h       = (image_height == '0) ? HW'(1) : image_height;
  assign all_in      = (in_row >= eff_h);
  assign in_col_end  = ((WW'(in_col) + WW'(1)) >= eff_w);
  assign out_col_end = ((WW'(out_col) + WW'(1)) >= eff_w);
  assign out_row_end = (out_row >= (eff_h - HW'(1)));
  assign pix_emit    = (in_row >= HW'(2)) || ((in_row == HW'(1)) && (in_col != '0));

  always_comb begin
    push_op          = '0;
    push_op.px       = in_px;
    push_op.top_ok   = (out_row != '0);
    push_op.bot_ok   = !out_row_end;
    push_op.left_ok  = (out_col != '0);
    push_op.right_ok = !out_col_end;
    push_op.last     = out_row_end && out_col_end;
    push_op.wr_bank  = in_row[0];
    push_addr        = in_col;
    push             = 1'b0;
    out_adv          = 1'b0;
    if (!is_flush) begin
      push_op.kind = bb3_pkg::OP_PIXEL;
      push_op.emit = pix_emit;
      push         = accept && !all_in;
      out_adv      = pix_emit;
    end else begin
      // last row drains from the line stores, else from the window
      push_op.kind   = out_row_end ? bb3_pkg::OP_FLUSH_STORE : bb3_pkg::OP_FLUSH_WIN;
      push_op.emit   = 1'b1;
      push_addr      = out_col;
      push           = accept && all_in;
      out_adv        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bb3_pkg::DEF_IMAGE_WIDTH;
      image_height <= bb3_pkg::DEF_IMAGE_HEIGHT;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == bb3_pkg::CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[bb3_pkg::IMG_WIDTH_W-1:0];
      end else begin
        image_height <= cfg_data[HW-1:0];
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (push) begin
      if (!is_flush) begin
        if (in_col_end) begin
          in_col <= '0;
          in_row <= in_row + HW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (out_adv) begin
        if (push_op.last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_end) begin
          out_col <= '0;
          out_row <= out_row + HW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

endmodule

FILE: src/bb3_back.sv
module bb3_back #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH,
  parameter int unsigned CW        = $clog2(MAX_WIDTH),
  parameter int unsigned QW        = $bits(bb3_pkg::op_t) + CW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [QW-1:0]               q_dout,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bb3_pkg::PIX_W-1:0]   out_data,
  output logic                        out_last
);

  localparam int unsigned OP_W = $bits(bb3_pkg::op_t);

  bb3_pkg::op_t    q_op;
  logic [CW-1:0]   q_addr;
  logic [CW-1:0]   addr_a;
  logic            en;

  // line stores, one bank per row parity
  bb3_pkg::pixel_t bank0 [MAX_WIDTH];
  bb3_pkg::pixel_t bank1 [MAX_WIDTH];
  bb3_pkg::pixel_t rd0a, rd0b, rd1a, rd1b;

  logic            s1_valid;
  bb3_pkg::op_t    s1_op;

  bb3_pkg::column_t win1, win2;
  bb3_pkg::column_t col_l, col_m, col_r, col_new, col_b;
  bb3_pkg::pixel_t  up_a, lo_a, up_b, lo_b;
  logic [2:0]       row_ok, col_ok;
  logic [bb3_pkg::CNT_W-1:0] n;
  logic [2:0][bb3_pkg::T_W-1:0] t;

  logic                          s2_valid;
  logic                          s2_last;
  logic [2:0][bb3_pkg::T_W-1:0]  s2_t;
  logic [bb3_pkg::RECIP_W-1:0]   s2_recip;

  logic                             s3_valid;
  logic                             s3_last;
  logic [2:0][bb3_pkg::PROD_W-1:0]  s3_prod;

  assign q_op   = bb3_pkg::op_t'(q_dout[OP_W-1:0]);
  assign q_addr = q_dout[OP_W +: CW];
  assign addr_a = (q_op.kind == bb3_pkg::OP_FLUSH_STORE) ? q_addr + CW'(1) : q_addr;
  assign en     = !s3_valid || out_ready;
  assign pop    = en && !q_empty;

  // stage 1: store read, pixel write (old data read back)
  always_ff @(posedge clk) begin
    if (en) begin
      rd0a <= bank0[addr_a];
      rd0b <= bank0[q_addr];
      if (pop && q_op.kind == bb3_pkg::OP_PIXEL && !q_op.wr_bank) begin
        bank0[q_addr] <= q_op.px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd1a <= bank1[addr_a];
      rd1b <= bank1[q_addr];
      if (pop && q_op.kind == bb3_pkg::OP_PIXEL && q_op.wr_bank) begin
        bank1[q_addr] <= q_op.px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= q_op;
    end
  end

  // stage 2: window and sums
  assign up_a = s1_op.wr_bank ? rd1a : rd0a;
  assign lo_a = s1_op.wr_bank ? rd0a : rd1a;
  assign up_b = s1_op.wr_bank ? rd1b : rd0b;
  assign lo_b = s1_op.wr_bank ? rd0b : rd1b;

  always_comb begin
    logic [bb3_pkg::SUM_W-1:0] sum;
    logic [1:0]                ncols;
    logic [1:0]                nrows;
    col_new = {s1_op.px, lo_a, up_a};
    col_b   = {bb3_pkg::pixel_t'(0), lo_b, up_b};
    unique case (s1_op.kind)
      bb3_pkg::OP_FLUSH_STORE: begin
        col_l = win2;
        col_m = col_b;
        col_r = {bb3_pkg::pixel_t'(0), lo_a, up_a};
      end
      default: begin
        col_l = win1;
        col_m = win2;
        col_r = col_new;
      end
    endcase
    row_ok = {s1_op.bot_ok, 1'b1, s1_op.top_ok};
    col_ok = {s1_op.right_ok, 1'b1, s1_op.left_ok};
    ncols  = 2'd1 + 2'(s1_op.left_ok) + 2'(s1_op.right_ok);
    nrows  = 2'd1 + 2'(s1_op.top_ok) + 2'(s1_op.bot_ok);
    n      = bb3_pkg::CNT_W'(ncols) * bb3_pkg::CNT_W'(nrows);
    for (int k = 0; k < 3; k++) begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        sum = sum
          + ((col_ok[0] && row_ok[i]) ? bb3_pkg::SUM_W'(col_l[i][k*bb3_pkg::CH_W +: bb3_pkg::CH_W]) : '0)
          + ((col_ok[1] && row_ok[i]) ? bb3_pkg::SUM_W'(col_m[i][k*bb3_pkg::CH_W +: bb3_pkg::CH_W]) : '0)
          + ((col_ok[2] && row_ok[i]) ? bb3_pkg::SUM_W'(col_r[i][k*bb3_pkg::CH_W +: bb3_pkg::CH_W]) : '0);
      end
      t[k] = {sum, 1'b0} + bb3_pkg::T_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      unique case (s1_op.kind)
        bb3_pkg::OP_PIXEL: begin
          win1 <= win2;
          win2 <= col_new;
        end
        bb3_pkg::OP_FLUSH_STORE: begin
          win2 <= col_b;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_op.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last  <= s1_op.last;
      s2_t     <= t;
      s2_recip <= bb3_pkg::recip(n);
    end
  end

  // stage 3: rounded mean by reciprocal multiply; doubles as output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      for (int k = 0; k < 3; k++) begin
        s3_prod[k] <= bb3_pkg::PROD_W'(s2_t[k]) * bb3_pkg::PROD_W'(s2_recip);
      end
    end
  end

  assign out_valid = s3_valid;
  assign out_last  = s3_last;
  assign out_data  = {s3_prod[2][bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W],
                      s3_prod[1][bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W],
                      s3_prod[0][bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W]};

endmodule

FILE: src/box_blur_3x3_rgb_unit.sv
// 3x3 box blur over a raster-order stream of 24-bit RGB pixels.
// Input stream: one transfer per pixel (tuser = 0) or flush (tuser = 1).
// Each result is the per-channel mean of the in-frame 3x3 neighborhood,
// rounded to nearest with halves up; tlast marks the frame's last pixel.
// Output lags input by image_width + 1 items: after a frame's last pixel,
// send one flush per pending pixel. Pixels sent while draining and flushes
// sent mid-frame are dropped with no result.
// Config port: index 0 = image_width, 1 = image_height; either write
// restarts the frame. Write only while the block is idle.
// Throughput: one item per cycle while the receiver keeps up. A front end
// classifies items and tracks frame position, a 4-entry queue decouples it
// from a 3-stage back end (line-store read, window sum, reciprocal multiply
// into the output register). When the receiver stalls, the back end holds,
// the queue fills and s_axis_tready drops after at most four more queued items.
// Reset (rst, synchronous) clears counters and valids and restores the
// default 1024x768 frame; line-store contents are kept and need no clear.
module box_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // in_red, in_green, in_blue
  input  logic                           s_axis_tuser,   // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // out_red, out_green, out_blue
  output logic                           m_axis_tlast,   // frame_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned QW = $bits(bb3_pkg::op_t) + CW;

  logic            push;
  bb3_pkg::op_t    push_op;
  logic [CW-1:0]   push_addr;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic [QW-1:0]   q_dout;

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .in_px     (s_axis_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_op   (push_op),
    .push_addr (push_addr),
    .q_full    (q_full)
  );

  bb3_queue #(
    .W     (QW),
    .DEPTH (bb3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_addr, push_op}),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .QW        (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: src/bb3_checker.sv
module bb3_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [23:0]                    s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [23:0]                    m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           cfg_index,
  input logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_rst_clear: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // three stages deep: no result just after reset is released
  a_startup: assert property (@(posedge clk) rst ##1 !rst |=> !m_axis_tvalid)
    else $error("result too early after reset");

  // input backpressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (.*);

FILE: tb/box_blur_3x3_rgb_checker.sv
module box_blur_3x3_rgb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [23:0]                    m_axis_tdata,
  input  logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bb3_pkg::*;

  localparam int LINE_LEN = 1024;

  typedef struct packed {
    logic [23:0] rgb;   // red in low byte
    logic        last;
  } blur_px_t;

  blur_px_t    blur_q[$];
  logic [23:0] upper_row[LINE_LEN];
  logic [23:0] lower_row[LINE_LEN];
  logic [23:0] win[3][3];   // [column][0 top, 1 middle, 2 bottom]
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  int          in_col, in_row, out_col, out_row;
  int          acc[3];
  int          cnt;

  assign pending = blur_q.size();

  function automatic int eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > LINE_LEN) return LINE_LEN;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  task automatic restart();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
  endtask

  task automatic add_px(logic [23:0] px);
    for (int k = 0; k < 3; k++) acc[k] += int'(px[8*k +: 8]);
    cnt++;
  endtask

  task automatic add_col(logic [23:0] t, logic [23:0] m, logic [23:0] b,
                         bit t_ok, bit b_ok);
    if (t_ok) add_px(t);
    add_px(m);
    if (b_ok) add_px(b);
  endtask

  task automatic push_mean(int w, int h);
    blur_px_t e;
    e.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    for (int k = 0; k < 3; k++)
      e.rgb[8*k +: 8] = 8'((2 * acc[k] + cnt) / (2 * cnt));
    blur_q.push_back(e);
    if (e.last) restart();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic predict(cmd_t cmd, logic [23:0] px);
    int          w, h, x;
    bit          top_ok, bot_ok, emit;
    logic [23:0] col_new[3];
    w = eff_w();
    h = eff_h();
    top_ok = out_row >= 1;
    bot_ok = out_row + 1 < h;
    acc = '{0, 0, 0};
    cnt = 0;
    if (cmd == CMD_PIXEL) begin
      // pixels arriving during drain fall out here
      if (in_row >= h || in_col >= w) return;
      x = in_col;
      col_new[0] = upper_row[x];
      col_new[1] = lower_row[x];
      col_new[2] = px;
      upper_row[x] = lower_row[x];
      lower_row[x] = px;
      emit = in_row >= 2 || (in_row == 1 && x >= 1);
      if (emit) begin
        if (out_col >= 1) add_col(win[1][0], win[1][1], win[1][2], top_ok, bot_ok);
        add_col(win[2][0], win[2][1], win[2][2], top_ok, bot_ok);
        if (out_col + 1 < w) add_col(col_new[0], col_new[1], col_new[2], top_ok, bot_ok);
      end
      win[0] = win[1];
      win[1] = win[2];
      win[2] = col_new;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (emit) push_mean(w, h);
    end else begin
      if (in_row < h) return;   // flush before frame end: no effect
      if (out_row + 1 >= h) begin
        // last row comes straight out of the line stores
        for (int d = -1; d <= 1; d++) begin
          if (d < 0 && out_col == 0) continue;
          x = out_col + d;
          if (x >= w) continue;
          add_col(upper_row[x], lower_row[x], '0, top_ok, 1'b0);
        end
      end else begin
        if (out_col >= 1) add_col(win[1][0], win[1][1], win[1][2], top_ok, bot_ok);
        add_col(win[2][0], win[2][1], win[2][2], top_ok, bot_ok);
      end
      push_mean(w, h);
    end
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < LINE_LEN; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = DEF_IMAGE_WIDTH;
      height_reg = DEF_IMAGE_HEIGHT;
      restart();
      blur_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index_t'(cfg_index) == CFG_IMAGE_WIDTH) width_reg = cfg_data[10:0];
        else height_reg = cfg_data;
        restart();
      end
      if (s_axis_tvalid && s_axis_tready)
        predict(cmd_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (blur_q.size() == 0) begin
          $display("%0t: unexpected result rgb=%h last=%b", $time, m_axis_tdata,
                   m_axis_tlast);
          errors++;
        end else begin
          blur_px_t e;
          e = blur_q.pop_front();
          for (int k = 0; k < 3; k++)
            if (m_axis_tdata[8*k +: 8] !== e.rgb[8*k +: 8]) begin
              $display("%0t: channel %0d expected %h actual %h", $time, k,
                       e.rgb[8*k +: 8], m_axis_tdata[8*k +: 8]);
              errors++;
            end
          if (m_axis_tlast !== e.last) begin
            $display("%0t: tlast expected %b actual %b", $time, e.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end
endmodule

FILE: tb/box_blur_3x3_rgb_unit_tb.sv
module box_blur_3x3_rgb_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bb3_pkg::*;

  localparam int STALL_LIMIT = 4000;   // cycles with no transfer at all
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;      // in_red, in_green, in_blue
  logic        s_axis_tuser = CMD_PIXEL; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // out_red, out_green, out_blue
  logic        m_axis_tlast;           // frame_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending;
  int send_idle_pct = 0;   // sender gap probability, percent
  int recv_idle_pct = 0;   // receiver stall probability, percent
  bit hold_req = 1'b0;
  int stall_cnt = 0;
  int items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  box_blur_3x3_rgb_unit uut (.*);

  box_blur_3x3_rgb_checker chk (.*, .errors(errors), .pending(pending));

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_req = 1'b0;
    end else
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: any transfer on any channel resets the count
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      stall_cnt <= 0;
    else if (stall_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

  // one stream transfer; entered and left at a falling edge
  task automatic send(cmd_t cmd, logic [23:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // settle: all results in, then idle for anything still in flight
  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // whole frame: pixels, then one flush per pending output; noise adds
  // ignored flushes mid-frame, ignored pixels during the drain and a trailing flush
  task automatic run_frame(int wr, int hr, bit noise, bit max_px);
    int w, h, npx, nfl;
    logic [23:0] px;
    drain_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wr));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hr));
    w = (wr < 1) ? 1 : (wr > 1024) ? 1024 : wr;
    h = (hr == 0) ? 1 : hr;
    npx = w * h;
    nfl = (npx < w + 1) ? npx : w + 1;
    for (int i = 0; i < npx; i++) begin
      if (noise && $urandom_range(9) == 0) send(CMD_FLUSH, 24'($urandom));
      px = max_px ? 24'hFFFFFF : 24'($urandom);
      send(CMD_PIXEL, px);
    end
    for (int i = 0; i < nfl; i++) begin
      if (noise && i < nfl - 1 && $urandom_range(9) == 0)
        send(CMD_PIXEL, 24'($urandom));
      send(CMD_FLUSH, 24'($urandom));
    end
    if (noise && $urandom_range(4) == 0) send(CMD_FLUSH, 24'($urandom));
  endtask

  task automatic random_frames(int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(19) == 0) run_frame(0, $urandom_range(4), 1'b1, 1'b0);
      else run_frame($urandom_range(1, 8), $urandom_range(1, 6), 1'b1, 1'b0);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 76;
    // directed: single pixel frame, all-ones pixels, width register zero,
    // height zero, an idle flush, noise items around a small frame
    run_frame(1, 1, 1'b0, 1'b0);
    run_frame(3, 3, 1'b0, 1'b1);
    run_frame(0, 2, 1'b0, 1'b0);
    run_frame(2, 0, 1'b0, 1'b0);
    send(CMD_FLUSH, 24'h0);              // idle flush, ignored
    run_frame(4, 2, 1'b1, 1'b0);
    random_frames(270);

    send_idle_pct = 76;
    recv_idle_pct = 24;
    random_frames(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long hold-off while the sender keeps streaming
    fork
      run_frame(40, 4, 1'b0, 1'b0);
      begin
        wait (pending > 0);
        hold_req = 1'b1;
      end
    join
    random_frames(220);
    run_frame(1, 12, 1'b0, 1'b0);        // tall single-column frame
    drain_idle();

    if (errors == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
